// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// widths and constants of the triangle unit normal pipeline
// ----------------------------------------------------------------------------
package tun_pkg;

  // field widths
  localparam int CW  = 24;
  localparam int NW  = 16;
  localparam int FB  = NW - 2;

  // internal widths
  localparam int EW  = CW + 1;        // edge vector component
  localparam int PW  = 2 * EW;        // edge product
  localparam int NCW = PW + 1;        // signed cross component
  localparam int MW  = PW;            // cross component magnitude
  localparam int HW  = MW / 2;        // half of a magnitude for squaring
  localparam int SW  = 2 * MW;        // squared component
  localparam int LW  = SW + 2;        // squared length
  localparam int QW  = 2 * FB + 3;    // scaled ratio c^2 * 2^(2F+2) / len^2
  localparam int RW  = FB + 2;        // integer root of that ratio

  localparam int LANE_LAT = QW + RW;
  localparam int NORM_ONE = 2 ** FB;

endpackage

// File: rtl/tun_ifs.sv
// ----------------------------------------------------------------------------
// tun_ifs
// valid/ready channels for triangles in and unit normals out
// ----------------------------------------------------------------------------
interface tun_in_if import tun_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [CW-1:0] a_x, a_y, a_z;
  logic signed [CW-1:0] b_x, b_y, b_z;
  logic signed [CW-1:0] c_x, c_y, c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

interface tun_out_if import tun_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [NW-1:0] norm_x, norm_y, norm_z;
  logic              degenerate;

  modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
  modport sink   (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

// File: rtl/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// unit face normal of a triangle, exact rounding, fully pipelined
// ----------------------------------------------------------------------------
// Usage:
//   in_tri carries one triangle per item: vertices a, b, c in signed Q12.12.
//   out_nrm carries the unit normal (c-a) x (b-a) / |.| as signed Q1.14,
//   rounded to nearest with ties away from zero, plus a degenerate flag that
//   is set (with a zero normal) when the cross product is the zero vector.
//   From accept to out_nrm.valid the pipeline has 55 register stages:
//   7 of edge, product, cross and squared length, 31 restoring divide
//   stages, 16 restoring square-root stages and the output register.
//   Throughput is one item per cycle while out_nrm is not stalled; every
//   stage is registered and the divide and root lanes run one per component.
//   Reset (rst_n low, synchronous) clears all valid bits; the pipeline comes
//   out empty and ready.
//   When the receiver holds out_nrm.ready low with a result waiting, the
//   whole pipeline holds and in_tri.ready drops; nothing is lost or repeated.
//   Empty slots keep moving while the output register is free.
// ----------------------------------------------------------------------------
module triangle_unit_normal import tun_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tun_in_if.sink    in_tri,
  tun_out_if.source out_nrm
);

  logic en;
  logic out_valid_r;

  logic signed [EW-1:0]  e1_r [3];
  logic signed [EW-1:0]  e2_r [3];
  logic signed [PW-1:0]  p_r  [6];
  logic signed [NCW-1:0] n_r  [3];
  logic [MW-1:0]         mag_r [3];
  logic [2*HW-1:0]       hh_r [3];
  logic [2*HW-1:0]       hl_r [3];
  logic [2*HW-1:0]       ll_r [3];
  logic [SW-1:0]         c2_r [3];
  logic [SW-1:0]         c2b_r [3];
  logic [LW-1:0]         len_r;
  logic [2:0]            neg4_r, neg5_r, neg6_r, neg7_r;
  logic                  deg4_r, deg5_r, deg6_r, deg7_r;
  logic                  v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic [LANE_LAT-1:0]   vq_r, dq_r;

  logic [RW-1:0]         root_w [3];
  logic [2:0]            nego_w;
  logic [FB:0]           m_w [3];
  logic signed [NW-1:0]  norm_nxt [3];
  logic signed [NW-1:0]  norm_r [3];
  logic                  deg_r;

  // whole pipeline moves unless a result is stuck at the output
  assign en           = !out_valid_r || out_nrm.ready;
  assign in_tri.ready = en;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
      vq_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tri.valid;
      v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r;
      vq_r <= {vq_r[LANE_LAT-2:0], v7_r};
      out_valid_r <= vq_r[LANE_LAT-1];
    end
  end

  // stages 1 to 7: edges, products, cross, magnitude, squares, length
  always_ff @(posedge clk) begin
    if (en) begin
      e1_r[0] <= EW'(in_tri.b_x) - EW'(in_tri.a_x);
      e1_r[1] <= EW'(in_tri.b_y) - EW'(in_tri.a_y);
      e1_r[2] <= EW'(in_tri.b_z) - EW'(in_tri.a_z);
      e2_r[0] <= EW'(in_tri.c_x) - EW'(in_tri.a_x);
      e2_r[1] <= EW'(in_tri.c_y) - EW'(in_tri.a_y);
      e2_r[2] <= EW'(in_tri.c_z) - EW'(in_tri.a_z);

      p_r[0] <= PW'(e2_r[1]) * PW'(e1_r[2]);
      p_r[1] <= PW'(e2_r[2]) * PW'(e1_r[1]);
      p_r[2] <= PW'(e2_r[2]) * PW'(e1_r[0]);
      p_r[3] <= PW'(e2_r[0]) * PW'(e1_r[2]);
      p_r[4] <= PW'(e2_r[0]) * PW'(e1_r[1]);
      p_r[5] <= PW'(e2_r[1]) * PW'(e1_r[0]);

      for (int k = 0; k < 3; k++) begin
        n_r[k]    <= NCW'(p_r[2*k]) - NCW'(p_r[2*k+1]);
        mag_r[k]  <= n_r[k][NCW-1] ? MW'(-n_r[k]) : MW'(n_r[k]);
        neg4_r[k] <= n_r[k][NCW-1];
        hh_r[k]   <= (2*HW)'(mag_r[k][MW-1:HW]) * (2*HW)'(mag_r[k][MW-1:HW]);
        hl_r[k]   <= (2*HW)'(mag_r[k][MW-1:HW]) * (2*HW)'(mag_r[k][HW-1:0]);
        ll_r[k]   <= (2*HW)'(mag_r[k][HW-1:0]) * (2*HW)'(mag_r[k][HW-1:0]);
        c2_r[k]   <= (SW'(hh_r[k]) << (2*HW)) + (SW'(hl_r[k]) << (HW+1)) + SW'(ll_r[k]);
        c2b_r[k]  <= c2_r[k];
      end
      deg4_r <= (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);

      neg5_r <= neg4_r; neg6_r <= neg5_r; neg7_r <= neg6_r;
      deg5_r <= deg4_r; deg6_r <= deg5_r; deg7_r <= deg6_r;

      len_r <= LW'(c2_r[0]) + LW'(c2_r[1]) + LW'(c2_r[2]);
      dq_r  <= {dq_r[LANE_LAT-2:0], deg7_r};
    end
  end

  // divide and root lanes, one per component
  for (genvar gk = 0; gk < 3; gk++) begin : g_lane
    tun_lane u_lane (
      .clk     (clk),
      .en      (en),
      .c2      (c2b_r[gk]),
      .len2    (len_r),
      .neg     (neg7_r[gk]),
      .root    (root_w[gk]),
      .neg_out (nego_w[gk])
    );
  end

  // round: m = (root + 1) / 2, then sign and degenerate override
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_w[k] = (FB+1)'(((RW+1)'(root_w[k]) + (RW+1)'(1)) >> 1);
      if (dq_r[LANE_LAT-1]) begin
        norm_nxt[k] = '0;
      end else if (nego_w[k]) begin
        norm_nxt[k] = -NW'(m_w[k]);
      end else begin
        norm_nxt[k] = NW'(m_w[k]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      norm_r <= norm_nxt;
      deg_r  <= dq_r[LANE_LAT-1];
    end
  end

  assign out_nrm.valid      = out_valid_r;
  assign out_nrm.norm_x     = norm_r[0];
  assign out_nrm.norm_y     = norm_r[1];
  assign out_nrm.norm_z     = norm_r[2];
  assign out_nrm.degenerate = deg_r;

endmodule

// File: rtl/tun_lane.sv
// ----------------------------------------------------------------------------
// tun_lane
// one normal component: restoring divide then restoring square root
// ----------------------------------------------------------------------------
module tun_lane import tun_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] c2,
  input  logic [LW-1:0] len2,
  input  logic          neg,
  output logic [RW-1:0] root,
  output logic          neg_out
);

  logic [LW-1:0] rem_r [QW-1];
  logic [LW-1:0] len_r [QW-1];
  logic [QW-1:0] q_r   [QW];
  logic [QW-1:0] rad_r [RW-1];
  logic [RW-1:0] root_r [RW];
  logic [LANE_LAT-1:0] ng_r;

  // divide: one quotient bit per stage, remainder below len2 whenever len2 is nonzero
  for (genvar gi = 0; gi < QW; gi++) begin : g_div
    logic [LW:0]   r2;
    logic [LW-1:0] lenv;
    logic [QW-1:0] qprev;
    logic          ge;

    if (gi == 0) begin : g_first
      assign r2    = (LW+1)'(c2);
      assign lenv  = len2;
      assign qprev = '0;
    end else begin : g_next
      assign r2    = {rem_r[gi-1], 1'b0};
      assign lenv  = len_r[gi-1];
      assign qprev = q_r[gi-1];
    end

    assign ge = r2 >= {1'b0, lenv};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[gi] <= {qprev[QW-2:0], ge};
      end
    end

    if (gi < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[gi] <= ge ? LW'(r2 - {1'b0, lenv}) : LW'(r2);
          len_r[gi] <= lenv;
        end
      end
    end
  end

  // square root: one root bit per stage, msb first
  for (genvar gj = 0; gj < RW; gj++) begin : g_sqrt
    localparam int B = RW - 1 - gj;
    logic [QW-1:0]   radv;
    logic [RW-1:0]   rootp;
    logic [RW-1:0]   t;
    logic [2*RW-1:0] sq;

    if (gj == 0) begin : g_first
      assign radv  = q_r[QW-1];
      assign rootp = '0;
    end else begin : g_next
      assign radv  = rad_r[gj-1];
      assign rootp = root_r[gj-1];
    end

    assign t  = rootp | (RW'(1) << B);
    assign sq = (2*RW)'(t) * (2*RW)'(t);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[gj] <= (sq <= (2*RW)'(radv)) ? t : rootp;
      end
    end

    if (gj < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[gj] <= radv;
        end
      end
    end
  end

  // sign travels alongside
  always_ff @(posedge clk) begin
    if (en) begin
      ng_r <= {ng_r[LANE_LAT-2:0], neg};
    end
  end

  assign root    = root_r[RW-1];
  assign neg_out = ng_r[LANE_LAT-1];

endmodule

// File: rtl/tun_checker.sv
// ----------------------------------------------------------------------------
// tun_checker
// port-level checks on the unit normal pipeline
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tun_checker import tun_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [NW-1:0] norm_x,
  input logic signed [NW-1:0] norm_y,
  input logic signed [NW-1:0] norm_z,
  input logic                 degenerate
);

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // the block only pushes back while its output is blocked
  `ASSERT_IMPLY(a_ready_free, clk, rst_n, !out_valid || out_ready, in_ready)

  // degenerate triangles give a zero normal
  `ASSERT_IMPLY(a_deg_zero, clk, rst_n, out_valid && degenerate, (norm_x | norm_y | norm_z) == '0)

  // nothing comes out the cycle after reset
  `ASSERT_NEXT(a_reset_empty, clk, 1'b1, !rst_n, !out_valid)

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_tri.ready),
  .out_valid  (out_nrm.valid),
  .out_ready  (out_nrm.ready),
  .norm_x     (out_nrm.norm_x),
  .norm_y     (out_nrm.norm_y),
  .norm_z     (out_nrm.norm_z),
  .degenerate (out_nrm.degenerate)
);

// File: verif/tun_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tun_scoreboard
// Watches both channels of the triangle unit normal pipeline. Every accepted
// triangle is turned into an exact expected normal, and every accepted result
// is compared field by field with the oldest expected normal.
// ----------------------------------------------------------------------------
module tun_scoreboard import tun_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tun_in_if    in_mon,
  tun_out_if   out_mon,
  output int   err_count,
  output int   normals_pending
);

  localparam int EXP_DEPTH = 256;

  typedef struct packed {
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
    logic                 degen;
  } normal_t;

  typedef logic [159:0] big_t;

  // expected normals in arrival order
  normal_t exp_mem [EXP_DEPTH];
  int      wr_cnt = 0;
  int      rd_cnt = 0;

  // round(|c| * 2^FB / sqrt(len2)) to nearest, ties away from zero
  function automatic longint unsigned scaled_root(big_t c, big_t len2);
    big_t            goal;
    big_t            lhs;
    longint unsigned m;
    longint unsigned cand;
    longint unsigned odd;
    goal = (c * c) << (2 * FB + 2);
    m = 0;
    for (int b = FB; b >= 0; b--) begin
      cand = m | (64'd1 << b);
      if (cand <= (64'd1 << FB)) begin
        odd = 2 * cand - 1;
        lhs = big_t'(odd * odd) * len2;
        if (lhs <= goal) m = cand;
      end
    end
    return m;
  endfunction

  function automatic normal_t face_normal(longint ax, longint ay, longint az,
                                          longint bx, longint by, longint bz,
                                          longint cx, longint cy, longint cz);
    longint          e1[3];
    longint          e2[3];
    longint          n[3];
    big_t            mag[3];
    big_t            len2;
    longint unsigned m;
    logic [NW-1:0]   comp[3];
    normal_t         r;
    e1[0] = bx - ax; e1[1] = by - ay; e1[2] = bz - az;
    e2[0] = cx - ax; e2[1] = cy - ay; e2[2] = cz - az;
    // cross product (c-a) x (b-a), exact in 64 bits
    n[0] = e2[1] * e1[2] - e2[2] * e1[1];
    n[1] = e2[2] * e1[0] - e2[0] * e1[2];
    n[2] = e2[0] * e1[1] - e2[1] * e1[0];
    len2 = '0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = big_t'(n[k] < 0 ? -n[k] : n[k]);
      len2 += mag[k] * mag[k];
    end
    if (len2 == '0) begin
      r = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      m = scaled_root(mag[k], len2);
      comp[k] = NW'(n[k] < 0 ? -longint'(m) : longint'(m));
    end
    r = '{nx: comp[0], ny: comp[1], nz: comp[2], degen: 1'b0};
    return r;
  endfunction

  assign normals_pending = wr_cnt - rd_cnt;

  // predict on triangle accept, compare on normal accept
  always @(posedge clk) begin
    normal_t got;
    normal_t want;
    if (!rst_n) begin
      err_count <= 0;
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        exp_mem[wr_cnt % EXP_DEPTH] = face_normal(in_mon.a_x, in_mon.a_y, in_mon.a_z,
                                                  in_mon.b_x, in_mon.b_y, in_mon.b_z,
                                                  in_mon.c_x, in_mon.c_y, in_mon.c_z);
        wr_cnt = wr_cnt + 1;
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{nx: out_mon.norm_x, ny: out_mon.norm_y, nz: out_mon.norm_z,
                degen: out_mon.degenerate};
        if (wr_cnt == rd_cnt) begin
          $display("%0t: unexpected normal x=%0d y=%0d z=%0d degenerate=%0b",
                   $realtime, got.nx, got.ny, got.nz, got.degen);
          err_count <= err_count + 1;
        end else begin
          want = exp_mem[rd_cnt % EXP_DEPTH];
          rd_cnt = rd_cnt + 1;
          if (got != want) begin
            $display("%0t: normal mismatch expected x=%0d y=%0d z=%0d deg=%0b",
                     $realtime, want.nx, want.ny, want.nz, want.degen);
            $display("%0t:                 actual   x=%0d y=%0d z=%0d deg=%0b",
                     $realtime, got.nx, got.ny, got.nz, got.degen);
            err_count <= err_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: verif/tb_triangle_unit_normal.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_unit_normal
// Drives triangles into the unit normal pipeline with random gaps, stalls
// the result side at random, and gives the verdict from the scoreboard's count.
// ----------------------------------------------------------------------------
module tb_triangle_unit_normal import tun_pkg::*;;

  localparam int RANDOM_TRIS = 750;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 80;

  typedef logic signed [CW-1:0] coord_t;

  logic   clk;
  logic   rst_n;
  int     err_count;
  int     normals_pending;
  int     idle_cycles;
  int     stall_left;
  coord_t vtx [9];

  tun_in_if  tri_ch ();
  tun_out_if nrm_ch ();

  triangle_unit_normal u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_tri (tri_ch),
    .out_nrm(nrm_ch)
  );

  tun_scoreboard u_scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (tri_ch),
    .out_mon         (nrm_ch),
    .err_count       (err_count),
    .normals_pending (normals_pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  // base moved by a random amount in [-span, span]
  function automatic coord_t offset_coord(coord_t base, int span);
    int d;
    d = int'($urandom_range(0, 2 * span)) - span;
    return base + coord_t'(d);
  endfunction

  // range ends and values around zero
  function automatic coord_t edge_coord();
    case ($urandom_range(0, 4))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return coord_t'(1);
    endcase
  endfunction

  // vertex layout: a at 0..2, b at 3..5, c at 6..8
  task automatic build_tri();
    int kind;
    int k;
    int d;
    kind = int'($urandom_range(0, 9));
    case (kind)
      0: begin // all three vertices coincide
        for (k = 0; k < 3; k++) vtx[k] = rand_coord();
        for (k = 3; k < 9; k++) vtx[k] = vtx[k % 3];
      end
      1: begin // collinear vertices
        for (k = 0; k < 3; k++) begin
          d = int'($urandom_range(0, 2046)) - 1023;
          vtx[k]   = offset_coord(coord_t'(0), 1 << 20);
          vtx[k+3] = vtx[k] + coord_t'(d);
          vtx[k+6] = vtx[k] + coord_t'(3 * d);
        end
      end
      2: begin // coordinates at the range ends
        for (k = 0; k < 9; k++) vtx[k] = edge_coord();
      end
      3: begin // right angle in the xy plane
        for (k = 0; k < 3; k++) vtx[k] = offset_coord(coord_t'(0), 1 << 20);
        for (k = 3; k < 9; k++) vtx[k] = vtx[k % 3];
        vtx[3] = offset_coord(vtx[0], 1 << 16);
        vtx[7] = offset_coord(vtx[1], 1 << 16);
      end
      4: begin // tiny triangle
        for (k = 0; k < 3; k++) vtx[k] = rand_coord();
        for (k = 3; k < 9; k++) vtx[k] = offset_coord(vtx[k % 3], 3);
      end
      default: begin
        for (k = 0; k < 9; k++) vtx[k] = rand_coord();
      end
    endcase
  endtask

  // reset, then triangles with random gaps, then drain and verdict
  initial begin
    int gap;
    rst_n        = 1'b0;
    tri_ch.valid = 1'b0;
    tri_ch.a_x = '0; tri_ch.a_y = '0; tri_ch.a_z = '0;
    tri_ch.b_x = '0; tri_ch.b_y = '0; tri_ch.b_z = '0;
    tri_ch.c_x = '0; tri_ch.c_y = '0; tri_ch.c_z = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int n = 0; n < RANDOM_TRIS; n++) begin
      gap = pick_gap();
      if (gap > 0) begin
        tri_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      build_tri();
      tri_ch.a_x = vtx[0]; tri_ch.a_y = vtx[1]; tri_ch.a_z = vtx[2];
      tri_ch.b_x = vtx[3]; tri_ch.b_y = vtx[4]; tri_ch.b_z = vtx[5];
      tri_ch.c_x = vtx[6]; tri_ch.c_y = vtx[7]; tri_ch.c_z = vtx[8];
      tri_ch.valid = 1'b1;
      @(posedge clk);
      while (!tri_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    tri_ch.valid = 1'b0;
    while (normals_pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side ready with random stalls
  initial begin
    nrm_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        nrm_ch.ready = 1'b0;
        stall_left--;
      end else begin
        stall_left   = pick_gap();
        nrm_ch.ready = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // watchdog on cycles in which no item moves
  always @(posedge clk) begin
    if (!rst_n || (tri_ch.valid && tri_ch.ready) || (nrm_ch.valid && nrm_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT - 1) begin
      $display("%0t: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: verif/tb_triangle_unit_normal_top.sv
`timescale 1ns / 100ps
